### hw/rtl/trq_pkg.sv
package trq_pkg;

    // Width of one stored value and of the configured initial value.
    localparam int VAL_W  = 40;
    // Width of a signed loss or value at risk.
    localparam int LOSS_W = 41;
    // Width of the confidence register.
    localparam int CONF_W = 16;
    // Width of the sample count field.
    localparam int CNT_OUT_W = 11;
    // Width of the configuration register index.
    localparam int CFG_IDX_W = 2;
    // Width of the radix bit index.
    localparam int BIT_W = 6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIDENCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL    = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [CONF_W-1:0] CONF_RESET = 16'd62259;
    localparam logic [VAL_W-1:0]  INIT_RESET = 40'd6553600;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_RANK,
        S_CLAMP,
        S_SCAN,
        S_SUM,
        S_DIVGO,
        S_DIV,
        S_OUT
    } t_state;

endpackage

### hw/rtl/trq_store.sv
module trq_store
    import trq_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [VAL_W-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [VAL_W-1:0] o_rdata
);

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/trq_div.sv
module trq_div
    import trq_pkg::*;
#(
    parameter int DW = 52,
    parameter int QW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [QW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    localparam int IW = $clog2(DW + 1);

    logic          r_busy;
    logic [IW-1:0] r_iter;
    logic [QW:0]   r_rem;
    logic [DW-1:0] r_quo;
    logic [QW-1:0] r_div;
    logic          r_done;
    logic [QW:0]   trial;
    logic [QW:0]   diff;
    logic          take;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb begin
        trial = {r_rem[QW-1:0], r_quo[DW-1]};
        take  = (trial >= {1'b0, r_div});
        diff  = trial - {1'b0, r_div};
    end

    // Control of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= IW'(DW - 1);
            end else if (r_busy) begin
                if (r_iter == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_iter <= r_iter - 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= take ? diff : trial;
            r_quo <= {r_quo[DW-2:0], take};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### hw/rtl/tail_risk_quantile.sv
// Channel   Direction  Handshake                 Payload
// request   in         i_in_valid / o_in_ready   i_final_value, i_last_sample
// result    out        o_res_valid / i_res_ready o_value_at_risk, o_expected_shortfall,
//                                                o_sample_count
// config    in         i_cfg_wr_en               i_cfg_idx, i_cfg_wdata
//
// Each accepted request, last or not, is stored while fewer than MAX_SAMPLES values are held.
// A last request starts a radix selection: 40 passes over the N stored values, one
// memory read per cycle, then one summing pass and a bit-serial divider, after which
// the result is registered; the single memory read port sets the length of this work.
// The request channel is not ready during that computation; it is ready while a result waits.
// Reset is synchronous and active low; the sample store itself is not cleared.
module tail_risk_quantile
    import trq_pkg::*;
#(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [VAL_W-1:0]            i_final_value,
    input  logic                        i_last_sample,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic signed [LOSS_W-1:0]    o_value_at_risk,
    output logic signed [LOSS_W-1:0]    o_expected_shortfall,
    output logic [CNT_OUT_W-1:0]        o_sample_count,
    input  logic                        i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [VAL_W-1:0]            i_cfg_wdata
);

    localparam int AW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int SUMW  = LOSS_W + CW;
    localparam int PRODW = CONF_W + 1 + CW;

    t_state r_state, n_state;

    logic [CONF_W-1:0]      r_conf;
    logic [VAL_W-1:0]       r_init;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_addr;
    logic                   r_pend;
    logic                   r_pend_last;
    logic [CW-1:0]          r_cnt;
    logic [CW-1:0]          r_rank;
    logic [PRODW-1:0]       r_prod;
    logic [VAL_W-1:0]       r_prefix;
    logic [BIT_W-1:0]       r_bit;
    logic signed [SUMW-1:0] r_sum;
    logic [CW-1:0]          r_tcnt;
    logic                   r_out_valid;
    logic signed [LOSS_W-1:0] r_var;
    logic signed [LOSS_W-1:0] r_es;
    logic [CNT_OUT_W-1:0]   r_out_cnt;

    logic                   in_acc;
    logic                   store_we;
    logic                   rd_issue;
    logic [VAL_W-1:0]       rdata;
    logic [VAL_W-1:0]       hi_mask;
    logic                   match;
    logic [CW-1:0]          cnt_fin;
    logic [CW:0]            rank_full;
    logic                   le_q;
    logic signed [LOSS_W-1:0] loss;
    logic signed [SUMW-1:0] sum_next;
    logic [SUMW-1:0]        sum_mag;
    logic                   div_done;
    logic [SUMW-1:0]        div_quo;
    logic signed [SUMW-1:0] es_full;
    logic                   out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign store_we   = in_acc && (r_count < CW'(MAX_SAMPLES));
    assign rd_issue   = ((r_state == S_SCAN) || (r_state == S_SUM)) && (r_addr < r_count);
    assign out_free   = !r_out_valid || i_res_ready;

    trq_store #(.DEPTH(MAX_SAMPLES), .AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_final_value),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (rdata)
    );

    // Magnitude of the tail sum goes to the divider; the sign is put back afterwards.
    assign sum_mag = r_sum[SUMW-1] ? SUMW'(-r_sum) : SUMW'(r_sum);

    trq_div #(.DW(SUMW), .QW(CW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DIVGO),
        .i_dividend (sum_mag),
        .i_divisor  (r_tcnt),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Per-read datapath: prefix match for selection, loss for the tail sum.
    always_comb begin
        hi_mask   = {VAL_W{1'b1}} << r_bit;
        match     = (((rdata ^ r_prefix) & hi_mask) == '0);
        cnt_fin   = r_cnt + CW'(match);
        rank_full = r_prod[PRODW-1:CONF_W];
        le_q      = (rdata <= r_prefix);
        loss      = $signed({1'b0, r_init}) - $signed({1'b0, rdata});
        sum_next  = r_sum + SUMW'(loss);
        es_full   = r_sum[SUMW-1] ? -$signed(div_quo) : $signed(div_quo);
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conf <= CONF_RESET;
            r_init <= INIT_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_CONFIDENCE: r_conf <= i_cfg_wdata[CONF_W-1:0];
                CFG_INITIAL:    r_init <= i_cfg_wdata;
                default:        ;
            endcase
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_acc && i_last_sample) n_state = S_RANK;
            S_RANK:  n_state = S_CLAMP;
            S_CLAMP: n_state = S_SCAN;
            S_SCAN:  if (r_pend && r_pend_last && (r_bit == '0)) n_state = S_SUM;
            S_SUM:   if (r_pend && r_pend_last) n_state = S_DIVGO;
            S_DIVGO: n_state = S_DIV;
            S_DIV:   if (div_done) n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sample count and read pipeline flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
        end else begin
            r_pend      <= rd_issue;
            r_pend_last <= rd_issue && (r_addr == r_count - 1'b1);
            if (store_we) begin
                r_count <= r_count + 1'b1;
            end else if ((r_state == S_OUT) && out_free) begin
                r_count <= '0;
            end
        end
    end

    // Selection and summing passes.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_RANK: begin
                r_prod <= PRODW'((CONF_W + 1)'(17'h10000 - {1'b0, r_conf}) * r_count);
            end
            S_CLAMP: begin
                r_rank   <= (rank_full >= {1'b0, r_count}) ? (r_count - 1'b1)
                                                           : rank_full[CW-1:0];
                r_prefix <= '0;
                r_bit    <= BIT_W'(VAL_W - 1);
                r_addr   <= '0;
                r_cnt    <= '0;
            end
            S_SCAN: begin
                if (rd_issue) r_addr <= r_addr + 1'b1;
                if (r_pend) begin
                    if (r_pend_last) begin
                        if (r_rank >= cnt_fin) begin
                            r_rank           <= r_rank - cnt_fin;
                            r_prefix[r_bit]  <= 1'b1;
                        end
                        r_addr <= '0;
                        r_cnt  <= '0;
                        r_sum  <= '0;
                        r_tcnt <= '0;
                        if (r_bit != '0) r_bit <= r_bit - 1'b1;
                    end else begin
                        r_cnt <= cnt_fin;
                    end
                end
            end
            S_SUM: begin
                if (rd_issue) r_addr <= r_addr + 1'b1;
                if (r_pend && le_q) begin
                    r_sum  <= sum_next;
                    r_tcnt <= r_tcnt + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && out_free) begin
            r_var     <= $signed({1'b0, r_init}) - $signed({1'b0, r_prefix});
            r_es      <= es_full[LOSS_W-1:0];
            r_out_cnt <= CNT_OUT_W'(r_count);
        end
    end

    assign o_res_valid          = r_out_valid;
    assign o_value_at_risk      = r_var;
    assign o_expected_shortfall = r_es;
    assign o_sample_count       = r_out_cnt;

    // The store never holds more than its capacity.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SAMPLES))
        else $error("sample count above capacity");

    // The tail always holds the selected value itself, so the divisor is nonzero.
    a_tail_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVGO) |-> (r_tcnt != '0))
        else $error("empty tail at division");

    // A new result appears only when leaving the output state.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result without computation");

    // No request is taken during the selection passes.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !o_in_ready)
        else $error("request taken while busy");

endmodule
